// File: src/qct_pkg.sv
// ----------------------------------------------------------------------------
// qct_pkg
// Types, codes and the default class table of the quoted comment tokenizer.
// ----------------------------------------------------------------------------
package qct_pkg;

    // Byte classes. All eight codes can be stored; code seven has no name
    // and falls through to the catch-all rows of the scanner.
    typedef logic [2:0] t_class;
    localparam t_class CLS_IGNORE  = 3'd0;
    localparam t_class CLS_SPACE   = 3'd1;
    localparam t_class CLS_LETTER  = 3'd2;
    localparam t_class CLS_COMMENT = 3'd3;
    localparam t_class CLS_QUOTE   = 3'd4;
    localparam t_class CLS_NEWLINE = 3'd5;
    localparam t_class CLS_END     = 3'd6;

    typedef enum logic [1:0] {
        CMD_DATA    = 2'd0,
        CMD_END     = 2'd1,
        CMD_SET     = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_TOKEN    = 2'd1,
        KIND_NO_MORE  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_SPACE    = 5'b00001,
        ST_WORD     = 5'b00010,
        ST_COMMENT  = 5'b00100,
        ST_QUOTE    = 5'b01000,
        ST_FINISHED = 5'b10000
    } t_state;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam logic [8:0]  FIELD_NONE = 9'h1FF;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  field_index;
        logic [15:0] record_number;
        logic [15:0] line_number;
        logic        last;
    } t_result;

    // Up to two results leave the scanner for one item.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic t_class default_class(logic [7:0] b);
        t_class c;
        c = CLS_LETTER;
        if (b inside {CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE}) begin
            c = CLS_SPACE;
        end else if (b == CH_LF) begin
            c = CLS_NEWLINE;
        end else if (b == CH_HASH) begin
            c = CLS_COMMENT;
        end else if (b inside {CH_DQUOTE, CH_SQUOTE}) begin
            c = CLS_QUOTE;
        end
        return c;
    endfunction

endpackage

// File: src/qct_intf.sv
// ----------------------------------------------------------------------------
// qct channel interfaces
// Valid/ready channels for input items, result items and configuration.
// ----------------------------------------------------------------------------
interface qct_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_byte;
    logic [2:0] class_code;

    modport source (output valid, command, char_byte, class_code, input ready);
    modport sink   (input valid, command, char_byte, class_code, output ready);
endinterface

interface qct_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  field_index;
    logic [15:0] record_number;
    logic [15:0] line_number;
    logic        last;

    modport source (output valid, kind, data_byte, field_index, record_number,
                    line_number, last, input ready);
    modport sink   (input valid, kind, data_byte, field_index, record_number,
                    line_number, last, output ready);
endinterface

interface qct_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: src/qct_class_table.sv
// ----------------------------------------------------------------------------
// qct_class_table
// 256-entry byte class memory with registered read.
// ----------------------------------------------------------------------------
module qct_class_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic            i_wr_en,
    input  logic [7:0]      i_addr,
    input  qct_pkg::t_class i_wr_class,
    output qct_pkg::t_class o_class
);
    import qct_pkg::*;

    t_class     r_mem [256];
    logic [255:0] r_valid;
    t_class     r_rd_data;
    logic       r_rd_valid;
    logic [7:0] r_rd_addr;

    // An entry never written since reset reads as its default class.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_class;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_addr];
            r_rd_valid <= r_valid[i_addr];
            r_rd_addr  <= i_addr;
        end
    end

    assign o_class = r_rd_valid ? r_rd_data : default_class(r_rd_addr);

endmodule

// File: src/qct_scanner.sv
// ----------------------------------------------------------------------------
// qct_scanner
// Scan state machine and counters; turns one classified item into results.
// ----------------------------------------------------------------------------
module qct_scanner #(
    parameter int MAX_TOKEN_LEN = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic [1:0]      i_command,
    input  logic [7:0]      i_char_byte,
    input  qct_pkg::t_class i_class,
    input  logic [7:0]      i_rec_fields,
    input  logic            i_room,
    output logic            o_ready,
    output qct_pkg::t_push  o_push
);
    import qct_pkg::*;

    localparam int LenW = $clog2(MAX_TOKEN_LEN + 3);
    localparam logic [LenW-1:0] LenLimit = LenW'(MAX_TOKEN_LEN + 2);

    logic             r_s1_valid;
    t_cmd             r_cmd;
    logic [7:0]       r_byte;

    t_state           r_state,   n_state;
    logic [LenW-1:0]  r_len,     n_len;
    logic             r_pending, n_pending;
    logic [15:0]      r_line,    n_line;
    logic [8:0]       r_field,   n_field;
    logic [15:0]      r_record,  n_record;

    logic             fire;
    logic             run;
    logic             fin_only;
    logic             act_add;
    logic             act_end;
    logic             fin;
    t_class           cls;
    logic [LenW-1:0]  len_inc;
    logic [8:0]       field_inc;
    t_kind            act_kind;
    logic [7:0]       act_byte;

    assign fire    = r_s1_valid && i_room;
    assign o_ready = !r_s1_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_load) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd  <= t_cmd'(i_command);
            r_byte <= i_char_byte;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_pending = r_pending;
        n_line    = r_line;
        n_field   = r_field;
        n_record  = r_record;
        run       = 1'b0;
        fin_only  = 1'b0;
        act_add   = 1'b0;
        act_end   = 1'b0;
        cls       = i_class;
        act_kind  = KIND_BYTE;
        act_byte  = 8'd0;
        len_inc   = r_len + 1'b1;
        field_inc = 9'd0;

        case (r_cmd)
            CMD_SET: begin
            end
            CMD_RESTART: begin
                n_state   = ST_SPACE;
                n_len     = '0;
                n_pending = 1'b0;
                n_line    = 16'd1;
                n_field   = FIELD_NONE;
                n_record  = 16'd1;
            end
            CMD_END: begin
                cls = CLS_END;
                if (r_state == ST_FINISHED) begin
                    fin_only = 1'b1;
                end else begin
                    run = 1'b1;
                end
            end
            default: begin
                run = (r_state != ST_FINISHED) && (i_class != CLS_IGNORE);
            end
        endcase

        if (run) begin
            if (r_pending && (r_line != COUNT_MAX)) begin
                n_line = r_line + 16'd1;
            end
            n_pending = (cls == CLS_NEWLINE);

            case (r_state)
                ST_SPACE: begin
                    case (cls)
                        CLS_LETTER: begin
                            act_add = 1'b1;
                            n_state = ST_WORD;
                        end
                        CLS_COMMENT: n_state = ST_COMMENT;
                        CLS_QUOTE:   n_state = ST_QUOTE;
                        CLS_END:     n_state = ST_FINISHED;
                        default:     n_state = ST_SPACE;
                    endcase
                end
                ST_WORD: begin
                    case (cls)
                        CLS_LETTER, CLS_QUOTE: act_add = 1'b1;
                        CLS_COMMENT: begin
                            act_end = 1'b1;
                            n_state = ST_COMMENT;
                        end
                        CLS_END: begin
                            act_end = 1'b1;
                            n_state = ST_FINISHED;
                        end
                        default: begin
                            act_end = 1'b1;
                            n_state = ST_SPACE;
                        end
                    endcase
                end
                ST_COMMENT: begin
                    if (cls == CLS_NEWLINE) begin
                        n_state = ST_SPACE;
                    end else if (cls == CLS_END) begin
                        n_state = ST_FINISHED;
                    end
                end
                ST_QUOTE: begin
                    if (cls == CLS_QUOTE) begin
                        act_end = 1'b1;
                        n_state = ST_SPACE;
                    end else if (cls == CLS_END) begin
                        act_end = 1'b1;
                        n_state = ST_FINISHED;
                    end else begin
                        act_add = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Emitted bytes and token ends both count against the length limit.
        if (act_add || act_end) begin
            if (len_inc >= LenLimit) begin
                n_len    = '0;
                act_kind = KIND_TOO_LONG;
            end else if (act_add) begin
                n_len    = len_inc;
                act_kind = KIND_BYTE;
                act_byte = r_byte;
            end else begin
                n_len     = '0;
                act_kind  = KIND_TOKEN;
                field_inc = (r_field == FIELD_NONE) ? 9'd0 : r_field + 9'd1;
                if (field_inc >= {1'b0, i_rec_fields}) begin
                    n_field = 9'd0;
                    if (r_record != COUNT_MAX) begin
                        n_record = r_record + 16'd1;
                    end
                end else begin
                    n_field = field_inc;
                end
            end
        end
    end

    assign fin = fin_only || (run && (n_state == ST_FINISHED));

    always_comb begin
        o_push = '0;
        o_push.r0.field_index   = n_field[7:0];
        o_push.r0.record_number = n_record;
        o_push.r0.line_number   = n_line;
        o_push.r1.field_index   = n_field[7:0];
        o_push.r1.record_number = n_record;
        o_push.r1.line_number   = n_line;
        o_push.r1.kind          = KIND_NO_MORE;
        o_push.r1.last          = 1'b1;
        if (act_add || act_end) begin
            o_push.v0           = fire;
            o_push.v1           = fire && fin;
            o_push.r0.kind      = act_kind;
            o_push.r0.data_byte = act_byte;
            o_push.r0.last      = !fin;
        end else begin
            o_push.v0      = fire && fin;
            o_push.r0.kind = KIND_NO_MORE;
            o_push.r0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SPACE;
            r_len     <= '0;
            r_pending <= 1'b0;
            r_line    <= 16'd1;
            r_field   <= FIELD_NONE;
            r_record  <= 16'd1;
        end else if (fire) begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_pending <= n_pending;
            r_line    <= n_line;
            r_field   <= n_field;
            r_record  <= n_record;
        end
    end

endmodule

// File: src/qct_out_queue.sv
// ----------------------------------------------------------------------------
// qct_out_queue
// Four-entry result queue that takes up to two results a cycle.
// ----------------------------------------------------------------------------
module qct_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qct_pkg::t_push  i_push,
    output logic            o_room,
    qct_out_if.source       o_out
);
    import qct_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    t_result          r_q [Depth];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [PtrW:0]    r_count;
    logic             pop;
    logic [PtrW:0]    push_n;
    t_result          head;

    assign pop    = o_out.valid && o_out.ready;
    assign push_n = (PtrW + 1)'(i_push.v0) + (PtrW + 1)'(i_push.v1);
    // Room for a worst-case item of two results.
    assign o_room = (r_count <= (PtrW + 1)'(Depth - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_q[r_wptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_q[r_wptr + 1'b1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + push_n[PtrW-1:0];
            r_count <= r_count + push_n - (PtrW + 1)'(pop);
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    assign head                = r_q[r_rptr];
    assign o_out.valid         = (r_count != '0);
    assign o_out.kind          = head.kind;
    assign o_out.data_byte     = head.data_byte;
    assign o_out.field_index   = head.field_index;
    assign o_out.record_number = head.record_number;
    assign o_out.line_number   = head.line_number;
    assign o_out.last          = head.last;

endmodule

// File: src/quoted_comment_tokenizer.sv
// ----------------------------------------------------------------------------
// An item is registered in the scan stage, and its first result in the result
// queue before it is offered; a queue without room holds the item in the scan stage.
// Throughput: one item per cycle while the sink takes one result per cycle;
// an item with two results needs a second transfer on the result port.
// Reset (synchronous, active low) restores the default class table at once via
// per-entry valid bits, empties the result queue and clears the field count.
// ----------------------------------------------------------------------------
// quoted_comment_tokenizer
// Table-driven byte tokenizer with comment and quote handling.
// ----------------------------------------------------------------------------
module quoted_comment_tokenizer #(
    parameter int MAX_TOKEN_LEN = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qct_in_if.sink    i_in,
    qct_out_if.source o_out,
    qct_cfg_if.sink   i_cfg
);
    import qct_pkg::*;

    logic       in_xfer;
    logic       scan_ready;
    logic       room;
    logic       set_cmd;
    t_class     cls;
    t_push      push;
    logic [7:0] r_rec_fields;

    // The configuration register is always writable; the user must write it only
    // while the block is idle, which the block does not enforce, so no item sees a change half way through.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_fields <= 8'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_rec_fields <= i_cfg.data;
        end
    end

    // An input transfer both loads the scan stage and issues the class table
    // access. A set command writes the table on its own transfer edge, so a
    // data byte right behind it already reads the new class.
    assign i_in.ready = scan_ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign set_cmd    = (t_cmd'(i_in.command) == CMD_SET);

    qct_class_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer),
        .i_wr_en    (in_xfer && set_cmd),
        .i_addr     (i_in.char_byte),
        .i_wr_class (t_class'(i_in.class_code)),
        .o_class    (cls)
    );

    // The scan stage holds one item together with the table read data. It
    // retires the item only when the queue has space for two results, which
    // also holds the table read register still during a stall.
    qct_scanner #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_xfer),
        .i_command     (i_in.command),
        .i_char_byte   (i_in.char_byte),
        .i_class       (cls),
        .i_rec_fields  (r_rec_fields),
        .i_room        (room),
        .o_ready       (scan_ready),
        .o_push        (push)
    );

    // The result queue parts the scan stage from the sink so that input keeps
    // flowing while a finished result waits for its transfer.
    qct_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
